FILE: rtl/dtq_pkg.sv
package dtq_pkg;

    localparam int ID_W   = 32;
    localparam int TIME_W = 48;
    localparam int DLY_W  = 32;
    localparam int CMD_W  = 3;
    localparam int KIND_W = 3;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [TIME_W-1:0] time_t;
    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [2:0]        op_t;

    localparam cmd_t CMD_AT       = 3'd0;
    localparam cmd_t CMD_DELAY    = 3'd1;
    localparam cmd_t CMD_CANCEL   = 3'd2;
    localparam cmd_t CMD_TICK     = 3'd3;
    localparam cmd_t CMD_SHUTDOWN = 3'd4;

    localparam kind_t K_ACCEPTED       = 3'd0;
    localparam kind_t K_FIRED          = 3'd1;
    localparam kind_t K_CANCELLED      = 3'd2;
    localparam kind_t K_NOTFOUND       = 3'd3;
    localparam kind_t K_FULL           = 3'd4;
    localparam kind_t K_AFTER_SHUTDOWN = 3'd5;
    localparam kind_t K_SHUTDOWN_DONE  = 3'd6;

    localparam op_t OP_HOLD         = 3'd0;
    localparam op_t OP_INSERT       = 3'd1;
    localparam op_t OP_REMOVE_ID    = 3'd2;
    localparam op_t OP_REMOVE_FRONT = 3'd3;
    localparam op_t OP_CLEAR        = 3'd4;

    typedef struct packed {
        logic  valid;
        id_t   id;
        time_t dl;
    } cell_t;

    typedef struct packed {
        op_t   op;
        id_t   key_id;
        time_t key_dl;
    } chain_ctrl_t;

    typedef struct packed {
        logic  full;
        logic  hit;
        cell_t front;
        cell_t second;
    } chain_stat_t;

    function automatic id_t next_id(input id_t id);
        next_id = (id == {ID_W{1'b1}}) ? id_t'(1) : id + id_t'(1);
    endfunction

endpackage

FILE: rtl/dtq_cell.sv
module dtq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  dtq_pkg::chain_ctrl_t ctrl,
    input  dtq_pkg::cell_t      left,
    input  logic                left_keep,
    input  dtq_pkg::cell_t      right,
    input  logic                match_in,
    output dtq_pkg::cell_t      data,
    output logic                keep,
    output logic                match_out
);

    logic               valid_reg;
    logic               valid_next;
    dtq_pkg::id_t       id_reg;
    dtq_pkg::id_t       id_next;
    dtq_pkg::time_t     dl_reg;
    dtq_pkg::time_t     dl_next;
    logic               match_self;

    assign data.valid = valid_reg;
    assign data.id    = id_reg;
    assign data.dl    = dl_reg;

    assign keep       = valid_reg && (dl_reg <= ctrl.key_dl);
    assign match_self = valid_reg && (id_reg == ctrl.key_id);
    assign match_out  = match_in || match_self;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        dl_next    = dl_reg;
        unique case (ctrl.op)
            dtq_pkg::OP_INSERT:
            begin
                priority if (keep)
                begin
                    valid_next = valid_reg;
                end
                else if (left.valid && !left_keep)
                begin
                    valid_next = left.valid;
                    id_next    = left.id;
                    dl_next    = left.dl;
                end
                else if (left_keep)
                begin
                    valid_next = 1'b1;
                    id_next    = ctrl.key_id;
                    dl_next    = ctrl.key_dl;
                end
                else
                begin
                    valid_next = valid_reg;
                end
            end
            dtq_pkg::OP_REMOVE_ID:
            begin
                if (match_out)
                begin
                    valid_next = right.valid;
                    id_next    = right.id;
                    dl_next    = right.dl;
                end
            end
            dtq_pkg::OP_REMOVE_FRONT:
            begin
                valid_next = right.valid;
                id_next    = right.id;
                dl_next    = right.dl;
            end
            dtq_pkg::OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        dl_reg <= dl_next;
    end

endmodule

FILE: rtl/dtq_chain.sv
module dtq_chain #(
    parameter int TASKS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dtq_pkg::chain_ctrl_t ctrl,
    output dtq_pkg::chain_stat_t stat
);

    dtq_pkg::cell_t cells [TASKS];
    logic           keep  [TASKS];
    logic           match [TASKS+1];

    assign match[0] = 1'b0;

    for (genvar i = 0; i < TASKS; i++)
    begin : g_cell
        dtq_pkg::cell_t left_c;
        dtq_pkg::cell_t right_c;
        logic           left_k;

        if (i == 0)
        begin : g_first
            assign left_c = '0;
            assign left_k = 1'b1;
        end
        else
        begin : g_mid
            assign left_c = cells[i-1];
            assign left_k = keep[i-1];
        end

        if (i == TASKS - 1)
        begin : g_end
            assign right_c = '0;
        end
        else
        begin : g_inner
            assign right_c = cells[i+1];
        end

        dtq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left      (left_c),
            .left_keep (left_k),
            .right     (right_c),
            .match_in  (match[i]),
            .data      (cells[i]),
            .keep      (keep[i]),
            .match_out (match[i+1])
        );
    end

    assign stat.full  = cells[TASKS-1].valid;
    assign stat.hit   = match[TASKS];
    assign stat.front = cells[0];

    if (TASKS > 1)
    begin : g_second
        assign stat.second = cells[1];
    end
    else
    begin : g_no_second
        assign stat.second = '0;
    end

endmodule

FILE: rtl/deadline_timer_queue.sv
// Each accepted command is registered and then executed: cancel, shutdown and a
// rejected schedule give their result directly; an accepted schedule first searches for
// a free id, stepping over each id in use; a tick advances time, then fires due tasks.
// The sequencer over the cell chain handles one item at a time: in_stall holds off a new
// command until the last one is through. An unused command gives no result.
// Reset clears all cell valid bits at once, time to 0 and the last id to 0.
module deadline_timer_queue #(
    parameter int TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [47:0] at_time,
    input  logic signed [31:0] delay,
    input  logic [31:0] task_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [31:0] task_id_res,
    output logic        last
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_FIRE   = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    dtq_pkg::time_t        time_reg;
    dtq_pkg::time_t        time_next;
    dtq_pkg::id_t          last_id_reg;
    dtq_pkg::id_t          last_id_next;
    logic                  shut_reg;
    logic                  shut_next;

    dtq_pkg::cmd_t         cmd_reg;
    dtq_pkg::time_t        at_time_reg;
    logic [31:0]           delay_reg;
    dtq_pkg::id_t          tid_reg;
    dtq_pkg::id_t          cand_reg;
    dtq_pkg::id_t          cand_next;
    dtq_pkg::time_t        dl_reg;
    dtq_pkg::time_t        dl_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    dtq_pkg::kind_t        kind_reg;
    dtq_pkg::kind_t        kind_next;
    dtq_pkg::id_t          res_reg;
    dtq_pkg::id_t          res_next;
    logic                  last_reg;
    logic                  last_next;

    dtq_pkg::chain_ctrl_t  ctrl;
    dtq_pkg::chain_stat_t  stat;

    logic                  accept;
    logic                  out_free;
    logic [48:0]           dly_sum;
    logic                  due0;
    logic                  due1;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign task_id_res = res_reg;
    assign last        = last_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    assign dly_sum = {1'b0, time_reg}
                   + (delay_reg[31] ? 49'd0 : {17'd0, delay_reg});
    assign due0    = stat.front.valid && (stat.front.dl <= time_reg);
    assign due1    = stat.second.valid && (stat.second.dl <= time_reg);

    dtq_chain #(
        .TASKS (TASKS)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        last_id_next   = last_id_reg;
        shut_next      = shut_reg;
        cand_next      = cand_reg;
        dl_next        = dl_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        res_next       = res_reg;
        last_next      = last_reg;
        ctrl.op        = dtq_pkg::OP_HOLD;
        ctrl.key_id    = (state_reg == S_SEARCH) ? cand_reg : tid_reg;
        ctrl.key_dl    = dl_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    unique case (cmd_reg)
                        dtq_pkg::CMD_AT, dtq_pkg::CMD_DELAY:
                        begin
                            if (cmd_reg == dtq_pkg::CMD_AT)
                            begin
                                dl_next = at_time_reg;
                            end
                            else
                            begin
                                dl_next = dly_sum[48] ? {dtq_pkg::TIME_W{1'b1}}
                                                      : dly_sum[47:0];
                            end
                            priority if (shut_reg)
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = dtq_pkg::K_AFTER_SHUTDOWN;
                                res_next       = '0;
                                last_next      = 1'b1;
                            end
                            else if (stat.full)
                            begin
                                out_valid_next = 1'b1;
                                kind_next      = dtq_pkg::K_FULL;
                                res_next       = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                cand_next  = dtq_pkg::next_id(last_id_reg);
                                state_next = S_SEARCH;
                            end
                        end
                        dtq_pkg::CMD_CANCEL:
                        begin
                            ctrl.op        = dtq_pkg::OP_REMOVE_ID;
                            out_valid_next = 1'b1;
                            kind_next      = stat.hit ? dtq_pkg::K_CANCELLED
                                                      : dtq_pkg::K_NOTFOUND;
                            res_next       = stat.hit ? tid_reg : '0;
                            last_next      = 1'b1;
                        end
                        dtq_pkg::CMD_TICK:
                        begin
                            if (time_reg != {dtq_pkg::TIME_W{1'b1}})
                            begin
                                time_next = time_reg + dtq_pkg::time_t'(1);
                            end
                            state_next = S_FIRE;
                        end
                        dtq_pkg::CMD_SHUTDOWN:
                        begin
                            ctrl.op        = dtq_pkg::OP_CLEAR;
                            shut_next      = 1'b1;
                            out_valid_next = 1'b1;
                            kind_next      = dtq_pkg::K_SHUTDOWN_DONE;
                            res_next       = '0;
                            last_next      = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (stat.hit)
                begin
                    cand_next = dtq_pkg::next_id(cand_reg);
                end
                else if (out_free)
                begin
                    ctrl.op        = dtq_pkg::OP_INSERT;
                    last_id_next   = cand_reg;
                    out_valid_next = 1'b1;
                    kind_next      = dtq_pkg::K_ACCEPTED;
                    res_next       = cand_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_FIRE:
            begin
                if (out_free)
                begin
                    if (due0)
                    begin
                        ctrl.op        = dtq_pkg::OP_REMOVE_FRONT;
                        out_valid_next = 1'b1;
                        kind_next      = dtq_pkg::K_FIRED;
                        res_next       = stat.front.id;
                        last_next      = !due1;
                        if (!due1)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            last_id_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= '0;
            last_id_reg   <= '0;
            shut_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            last_id_reg   <= last_id_next;
            shut_reg      <= shut_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd;
            at_time_reg <= at_time;
            delay_reg   <= delay;
            tid_reg     <= task_id;
        end
        cand_reg <= cand_next;
        dl_reg   <= dl_next;
        kind_reg <= kind_next;
        res_reg  <= res_next;
        last_reg <= last_next;
    end

endmodule
